// ===== rtl/hse_pkg.sv =====
package hse_pkg;

  // Depth of the command queue between the parser and the result expander.
  localparam int QUEUE_DEPTH = 4;

  // Bytes of a partial "/script" match that can be replayed.
  localparam int HOLD_LEN = 6;

  // Result kinds.
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic       first_of_script;
    logic       last_result;
  } out_item_t;

  // One parsed input byte, as a list of results for the back end to emit:
  // optional replay of '<' plus rep_len held bytes, optional body byte,
  // optional script-ended event, in that order.
  typedef struct packed {
    logic                     rep_en;
    logic [2:0]               rep_len;
    logic [HOLD_LEN-1:0][7:0] hold;
    logic                     byte_en;
    logic [7:0]               data;
    logic                     end_en;
    logic                     first;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/hse_front.sv =====
module hse_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  hse_pkg::in_item_t     in_item,
  output logic                  in_stall,
  input  hse_pkg::queue_status_t q_status,
  output logic                  push,
  output hse_pkg::cmd_t         cmd
);

  localparam logic [2:0] M_SEARCH      = 3'd0;
  localparam logic [2:0] M_OPEN_SKIP   = 3'd1;
  localparam logic [2:0] M_BODY        = 3'd2;
  localparam logic [2:0] M_AFTER_LT    = 3'd3;
  localparam logic [2:0] M_HEADER_SKIP = 3'd4;
  localparam logic [2:0] M_CLOSE_SKIP  = 3'd5;

  localparam logic [2:0] TAG_LAST = 3'd6;

  localparam logic [7:0] CH_LT  = 8'h3c;
  localparam logic [7:0] CH_GT  = 8'h3e;
  localparam logic [7:0] CH_EXC = 8'h21;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_S_L = 8'h73;
  localparam logic [7:0] CH_S_U = 8'h53;

  // Characters of "<script" / "<SCRIPT" at a position of the tag.
  function automatic logic [7:0] open_char(input logic upper, input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h3c;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h70;
      default: c = 8'h74;
    endcase
    if (upper && idx != 3'd0) begin
      c = c - 8'd32;
    end
    return c;
  endfunction

  // Characters of "/script".
  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2f;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h70;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  logic [2:0] mode_r, mode_nxt;
  logic [2:0] omc_r, omc_nxt;
  logic       upper_r, upper_nxt;
  logic [2:0] cmc_r, cmc_nxt;
  logic       started_r, started_nxt;
  logic [hse_pkg::HOLD_LEN-1:0][7:0] hold_r, hold_nxt;

  logic accept;
  logic [7:0] c;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign c        = in_item.data_byte;

  always_comb begin
    logic [2:0] k;
    mode_nxt    = mode_r;
    omc_nxt     = omc_r;
    upper_nxt   = upper_r;
    cmc_nxt     = cmc_r;
    started_nxt = started_r;
    hold_nxt    = hold_r;
    cmd         = '0;
    cmd.first   = !started_r;
    k           = '0;

    unique case (mode_r)
      M_SEARCH: begin
        if (omc_r == 3'd0) begin
          omc_nxt = (c == CH_LT) ? 3'd1 : 3'd0;
        end else if (omc_r == 3'd1) begin
          if (c == CH_S_L) begin
            upper_nxt = 1'b0;
            omc_nxt   = 3'd2;
          end else if (c == CH_S_U) begin
            upper_nxt = 1'b1;
            omc_nxt   = 3'd2;
          end else begin
            omc_nxt = (c == CH_LT) ? 3'd1 : 3'd0;
          end
        end else if (c == open_char(upper_r, omc_r)) begin
          if (omc_r == TAG_LAST) begin
            omc_nxt  = 3'd0;
            mode_nxt = M_OPEN_SKIP;
          end else begin
            omc_nxt = omc_r + 3'd1;
          end
        end else begin
          omc_nxt = (c == CH_LT) ? 3'd1 : 3'd0;
        end
      end
      M_OPEN_SKIP: begin
        if (c == CH_GT) begin
          mode_nxt = M_BODY;
        end
      end
      M_BODY: begin
        if (c == CH_LT) begin
          mode_nxt = M_AFTER_LT;
          cmc_nxt  = 3'd0;
        end else begin
          cmd.byte_en = 1'b1;
          cmd.data    = c;
          started_nxt = 1'b1;
        end
      end
      M_AFTER_LT: begin
        k = (cmc_r > TAG_LAST) ? 3'd0 : cmc_r;
        cmc_nxt = k;
        if (k == 3'd0 && c == CH_EXC && !started_r) begin
          mode_nxt = M_HEADER_SKIP;
        end else if (fold(c) == close_char(k)) begin
          if (k == TAG_LAST) begin
            cmd.end_en  = started_r;
            started_nxt = 1'b0;
            cmc_nxt     = 3'd0;
            mode_nxt    = M_CLOSE_SKIP;
          end else begin
            hold_nxt[k] = c;
            cmc_nxt     = k + 3'd1;
          end
        end else begin
          // Failed match: replay '<' and the held prefix, then treat c as body.
          cmd.rep_en  = 1'b1;
          cmd.rep_len = k;
          started_nxt = 1'b1;
          cmc_nxt     = 3'd0;
          if (c == CH_LT) begin
            mode_nxt = M_AFTER_LT;
          end else begin
            mode_nxt    = M_BODY;
            cmd.byte_en = 1'b1;
            cmd.data    = c;
          end
        end
      end
      M_HEADER_SKIP: begin
        if (c == CH_NL) begin
          mode_nxt    = M_BODY;
          cmd.byte_en = 1'b1;
          cmd.data    = c;
          started_nxt = 1'b1;
        end
      end
      M_CLOSE_SKIP: begin
        if (c == CH_GT) begin
          mode_nxt = M_SEARCH;
        end
      end
      default: begin
        mode_nxt = M_SEARCH;
        omc_nxt  = 3'd0;
      end
    endcase

    if (in_item.end_of_input) begin
      if (mode_nxt == M_AFTER_LT && cmc_nxt != 3'd0) begin
        cmd.rep_en  = 1'b1;
        cmd.rep_len = cmc_nxt;
        started_nxt = 1'b1;
      end
      if (started_nxt) begin
        cmd.end_en = 1'b1;
      end
      mode_nxt    = M_SEARCH;
      omc_nxt     = 3'd0;
      upper_nxt   = 1'b0;
      cmc_nxt     = 3'd0;
      started_nxt = 1'b0;
    end

    cmd.hold  = hold_nxt;
    cmd.first = cmd.first && (cmd.rep_en || cmd.byte_en);
  end

  assign push = accept && (cmd.rep_en || cmd.byte_en || cmd.end_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_SEARCH;
      omc_r     <= 3'd0;
      upper_r   <= 1'b0;
      cmc_r     <= 3'd0;
      started_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      omc_r     <= omc_nxt;
      upper_r   <= upper_nxt;
      cmc_r     <= cmc_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// ===== rtl/hse_queue.sv =====
module hse_queue #(
  parameter int DEPTH = hse_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hse_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output hse_pkg::cmd_t          head,
  output hse_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hse_pkg::cmd_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hse_back.sv =====
module hse_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hse_pkg::cmd_t          head,
  input  hse_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  output hse_pkg::out_item_t     out_item,
  input  logic                   out_stall
);

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r;
  hse_pkg::out_item_t out_item_r, item_nxt;

  logic [3:0] rep_cnt;
  logic [3:0] total;
  logic       load;
  logic       last;
  logic [2:0] hold_idx;

  assign rep_cnt  = head.rep_en ? {1'b0, head.rep_len} + 4'd1 : 4'd0;
  assign total    = rep_cnt + {3'b0, head.byte_en} + {3'b0, head.end_en};
  assign last     = (idx_r == total - 4'd1);
  assign load     = !q_status.empty && (!out_valid_r || !out_stall);
  assign pop      = load && last;
  assign hold_idx = 3'(idx_r - 4'd1);

  always_comb begin
    item_nxt                 = '0;
    item_nxt.last_result     = last;
    item_nxt.first_of_script = head.first && (idx_r == 4'd0);
    if (idx_r < rep_cnt) begin
      item_nxt.kind      = hse_pkg::KIND_BODY;
      item_nxt.body_byte = (idx_r == 4'd0) ? 8'h3c : head.hold[hold_idx];
    end else if (head.byte_en && idx_r == rep_cnt) begin
      item_nxt.kind      = hse_pkg::KIND_BODY;
      item_nxt.body_byte = head.data;
    end else begin
      item_nxt.kind = hse_pkg::KIND_END;
    end
    idx_nxt = last ? 4'd0 : idx_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/html_script_extractor_unit.sv =====
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+---------------------------------------
// input    | in_valid, in_stall, in_item    | one HTML byte plus end-of-input flag
// output   | out_valid, out_stall, out_item | one script byte or script-ended event
//
// The parser takes one byte per cycle while the queue has room; each byte is
// classified in that cycle and queued as one command if it has any result. The
// expander drains one result per cycle unless out_stall is high; a byte can have up
// to 9 results (failed close-tag replay at end of input), which the queue absorbs.
// Reset is synchronous, active low; it clears the parser state, the queue and the
// output valid. in_stall rises only while the queue is full; out_stall holds the
// output register and lets the queue fill behind it.
module html_script_extractor_unit #(
  parameter int QUEUE_DEPTH = hse_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  hse_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output hse_pkg::out_item_t out_item,
  input  logic               out_stall
);

  // Parser to queue: a command per byte that produces any result.
  logic                   q_push;
  hse_pkg::cmd_t          q_push_cmd;
  // Queue to expander: head command, advance on its last result.
  logic                   q_pop;
  hse_pkg::cmd_t          q_head;
  hse_pkg::queue_status_t q_status;

  // Front: tag matching, body/header/close-tag tracking, replay decisions.
  hse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_status (q_status),
    .push     (q_push),
    .cmd      (q_push_cmd)
  );

  // Decouple the parser from the result side.
  hse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // Back: expand each command into its result sequence through the output register.
  hse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // Never push into a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("command pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("command popped from empty queue");

  // A script-ended event is always the last result of its byte.
  a_end_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == hse_pkg::KIND_END) |-> out_item.last_result)
    else $error("script-ended event not marked last");

  // Only a body byte can open a script.
  a_first_is_body : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.first_of_script) |-> (out_item.kind == hse_pkg::KIND_BODY))
    else $error("first_of_script set on an event");

endmodule

// ===== tb/html_script_extractor_unit_tb.sv =====
`timescale 1ns / 100ps

module html_script_extractor_unit_tb;

  // Cycles without any accepted transaction before the run is declared hung.
  // The hold-off stretch is the longest legal quiet period, so stay well above it.
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  // Trailing cycles after the last expected result: enough for a full queue of
  // worst-case commands to show up if the block emits anything extra.
  localparam int DRAIN_CYCLES    = 60;

  localparam int          TAG_LEN    = 7;
  localparam logic [55:0] OPEN_LOWER = "<script";
  localparam logic [55:0] OPEN_UPPER = "<SCRIPT";
  localparam logic [55:0] CLOSE_TAG  = "/script";

  typedef enum logic [2:0] {
    SCAN_FOR_OPEN,
    SKIP_OPEN_TAG,
    IN_BODY,
    AFTER_LT,
    SKIP_HEADER,
    SKIP_CLOSE_TAG
  } scan_mode_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  hse_pkg::in_item_t  in_item   = '0;
  logic               in_stall;
  logic               out_valid;
  hse_pkg::out_item_t out_item;
  logic               out_stall = 1'b0;

  // Idle rates in percent; the receiver's rate is read by its own process.
  int   snd_idle_pct  = 0;
  int   rcv_idle_pct  = 0;
  // Toggle to request one long receiver hold-off.
  logic hold_off_req  = 1'b0;
  logic hold_off_seen = 1'b0;
  int   hold_off_left = 0;

  int   error_count   = 0;
  int   items_sent    = 0;
  int   quiet_cycles  = 0;

  // Scanner state mirrored from the block's behavior.
  scan_mode_e  scan_mode;
  logic [2:0]  open_cnt;
  logic        open_upper;
  logic [2:0]  close_cnt;
  logic        script_open;
  logic [7:0]  close_held [TAG_LEN];

  hse_pkg::out_item_t step_out[$];
  hse_pkg::out_item_t expected_results[$];
  logic [7:0]         doc_bytes[$];

  html_script_extractor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scanner prediction
  // ---------------------------------------------------------------------------

  // Pick character idx of a 7-character tag; the first character sits in the top byte.
  function automatic logic [7:0] tag_char(logic [55:0] tag, int idx);
    return tag[(TAG_LEN - 1 - idx) * 8 +: 8];
  endfunction

  // Fold ASCII upper case only; bytes above 127 stay as they are.
  function automatic logic [7:0] fold_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_scanner();
    scan_mode   = SCAN_FOR_OPEN;
    open_cnt    = '0;
    open_upper  = 1'b0;
    close_cnt   = '0;
    script_open = 1'b0;
    foreach (close_held[i]) close_held[i] = 8'h00;
  endfunction

  function automatic void add_result(logic kind, logic [7:0] b, logic first);
    hse_pkg::out_item_t r;
    r.kind            = kind;
    r.body_byte       = b;
    r.first_of_script = first;
    r.last_result     = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void emit_script_byte(logic [7:0] c);
    add_result(hse_pkg::KIND_BODY, c, !script_open);
    script_open = 1'b1;
  endfunction

  function automatic void take_body_byte(logic [7:0] c);
    if (c == "<") begin
      scan_mode = AFTER_LT;
      close_cnt = '0;
    end else begin
      emit_script_byte(c);
    end
  endfunction

  // Give back the '<' and the held part of a broken close tag, in original case.
  function automatic void replay_close_prefix();
    logic [2:0] n;
    n = (close_cnt > 3'd6) ? 3'd6 : close_cnt;
    emit_script_byte("<");
    for (int i = 0; i < n; i++) emit_script_byte(close_held[i]);
    close_cnt = '0;
  endfunction

  function automatic void match_open(logic [7:0] c);
    logic [2:0] k;
    logic [7:0] want;
    int         idx;
    k = open_cnt;
    if (k == 3'd0) begin
      if (c == "<") k = 3'd1;
    end else if (k == 3'd1) begin
      // The second character decides which spelling is being followed.
      if (c == "s") begin
        open_upper = 1'b0;
        k = 3'd2;
      end else if (c == "S") begin
        open_upper = 1'b1;
        k = 3'd2;
      end else begin
        k = (c == "<") ? 3'd1 : 3'd0;
      end
    end else begin
      idx  = (k < TAG_LEN) ? k : TAG_LEN - 1;
      want = tag_char(open_upper ? OPEN_UPPER : OPEN_LOWER, idx);
      if (c == want) begin
        if (k + 1 >= TAG_LEN) begin
          k = 3'd0;
          scan_mode = SKIP_OPEN_TAG;
        end else begin
          k = k + 3'd1;
        end
      end else begin
        k = (c == "<") ? 3'd1 : 3'd0;
      end
    end
    open_cnt = k;
  endfunction

  function automatic void match_close(logic [7:0] c);
    logic [2:0] k;
    k = (close_cnt > 3'd6) ? 3'd0 : close_cnt;
    close_cnt = k;
    if (k == 3'd0 && c == "!" && !script_open) begin
      scan_mode = SKIP_HEADER;
    end else if (fold_lower(c) == tag_char(CLOSE_TAG, k)) begin
      close_held[k] = c;
      if (k + 1 >= TAG_LEN) begin
        if (script_open) add_result(hse_pkg::KIND_END, 8'h00, 1'b0);
        script_open = 1'b0;
        close_cnt   = '0;
        scan_mode   = SKIP_CLOSE_TAG;
      end else begin
        close_cnt = k + 3'd1;
      end
    end else begin
      // Broken match: replay, then treat the failing byte as fresh body.
      replay_close_prefix();
      scan_mode = IN_BODY;
      take_body_byte(c);
    end
  endfunction

  // Work out every result one accepted byte causes and queue them in order.
  function automatic void predict_results(hse_pkg::in_item_t it);
    logic [7:0]         c;
    hse_pkg::out_item_t r;
    c = it.data_byte;
    step_out.delete();
    case (scan_mode)
      SCAN_FOR_OPEN:  match_open(c);
      SKIP_OPEN_TAG:  if (c == ">") scan_mode = IN_BODY;
      IN_BODY:        take_body_byte(c);
      AFTER_LT:       match_close(c);
      SKIP_HEADER: begin
        if (c == "\n") begin
          scan_mode = IN_BODY;
          take_body_byte(c);
        end
      end
      SKIP_CLOSE_TAG: if (c == ">") scan_mode = SCAN_FOR_OPEN;
      default: begin
        scan_mode = SCAN_FOR_OPEN;
        open_cnt  = '0;
      end
    endcase
    if (it.end_of_input) begin
      // A partial close tag at the end counts as broken; a lone '<' is dropped.
      if (scan_mode == AFTER_LT && close_cnt != 3'd0) replay_close_prefix();
      if (script_open) add_result(hse_pkg::KIND_END, 8'h00, 1'b0);
      clear_scanner();
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last_result = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted input. Both
  // channels are sampled at the edge, so pre-edge values decide acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hse_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d byte %0h", out_item.kind,
                 out_item.body_byte);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_item.kind);
            error_count++;
          end
          if (out_item.body_byte !== want.body_byte) begin
            $error("body_byte: expected %0h, actual %0h", want.body_byte,
                   out_item.body_byte);
            error_count++;
          end
          if (out_item.first_of_script !== want.first_of_script) begin
            $error("first_of_script: expected %0d, actual %0d", want.first_of_script,
                   out_item.first_of_script);
            error_count++;
          end
          if (out_item.last_result !== want.last_result) begin
            $error("last_result: expected %0d, actual %0d", want.last_result,
                   out_item.last_result);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_results(in_item);
    end
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("html_script_extractor_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one byte and return at the edge that accepts it. The caller must
  // either send again or drop valid in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    hse_pkg::in_item_t it;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= hse_pkg::in_item_t'(9'($urandom));
      @(posedge clk);
    end
    it.data_byte    = b;
    it.end_of_input = eoi;
    in_valid <= 1'b1;
    in_item  <= it;
    // Hold the payload until a transaction goes through.
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eoi_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] random_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  // Bias body bytes toward the characters the scanner reacts to.
  function automatic logic [7:0] body_symbol();
    case ($urandom_range(0, 9))
      0:       return "<";
      1:       return "/";
      2:       return "!";
      3:       return "\n";
      4:       return ">";
      5:       return random_case(tag_char(CLOSE_TAG, $urandom_range(1, 6)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endtask

  task automatic add_close_tag();
    doc_bytes.push_back("<");
    for (int i = 0; i < TAG_LEN; i++) doc_bytes.push_back(random_case(tag_char(CLOSE_TAG, i)));
  endtask

  // A close tag broken after a random number of characters.
  task automatic add_partial_close();
    int n;
    n = $urandom_range(0, 6);
    doc_bytes.push_back("<");
    for (int i = 0; i < n; i++) doc_bytes.push_back(random_case(tag_char(CLOSE_TAG, i)));
    doc_bytes.push_back(body_symbol());
  endtask

  // Build one document, mostly well formed, and send it with end-of-input on
  // its final byte.
  task automatic send_random_doc();
    int cut;
    doc_bytes.delete();
    repeat ($urandom_range(0, 4)) doc_bytes.push_back(body_symbol());
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 7))
        0:       add_text("<Script");
        1, 2, 3: add_text("<SCRIPT");
        default: add_text("<script");
      endcase
      if ($urandom_range(0, 2) == 0) add_text(" type=js");
      doc_bytes.push_back(">");
      if ($urandom_range(0, 3) == 0) add_text("<!-- hdr\n");
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 5) == 0) add_partial_close();
        else doc_bytes.push_back(body_symbol());
      end
      if ($urandom_range(0, 9) != 0) begin
        add_close_tag();
        if ($urandom_range(0, 2) == 0) add_text(" x");
        doc_bytes.push_back(">");
      end
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(body_symbol());
    end
    // Now and then cut the document short so it ends inside a tag or body.
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, doc_bytes.size());
      while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
    end
    foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  // Upper-case open tag, header line, byte extremes, and a close tag broken on
  // the final byte (the nine-result case).
  task automatic test_upper_tag_and_header();
    send_text("<SCRIPT>", 1'b0);
    send_text("<!x\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("</scripX", 1'b1);
  endtask

  // Mixed-case open tag, replay of a broken close, mixed-case close with
  // attributes, a high byte, a trailing lone '<', and unterminated tags.
  task automatic test_close_tag_cases();
    send_text("<Script><script>a<b</ScRiPt z><script>", 1'b0);
    send_byte(8'hC0, 1'b0);
    send_text("<", 1'b1);
    send_text("<s<script x", 1'b1);
    send_text("<script>z<!\n</script", 1'b1);
  endtask

  // Stall the output for a long stretch while bytes keep coming, so the
  // command queue fills and the input stalls.
  task automatic test_output_hold_off();
    snd_idle_pct  = 0;
    rcv_idle_pct <= 0;
    hold_off_req <= ~hold_off_req;
    send_text("<script>", 1'b0);
    repeat (40) send_byte(8'($urandom_range(8'h21, 8'h3B)), 1'b0);
    send_text("</script>", 1'b1);
  endtask

  task automatic test_random_docs(input int snd_pct, input int rcv_pct, input int n_items);
    int start;
    snd_idle_pct  = snd_pct;
    rcv_idle_pct <= rcv_pct;
    start = items_sent;
    while (items_sent - start < n_items) send_random_doc();
  endtask

  // Drop valid, then wait out every expected result plus a margin for strays.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clear_scanner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct  = 24;
    rcv_idle_pct <= 47;
    test_upper_tag_and_header();
    test_close_tag_cases();
    test_random_docs(24, 47, 40);
    test_random_docs(47, 24, 40);
    test_output_hold_off();
    test_random_docs(0, 0, 40);
    wait_for_drain();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("html_script_extractor_unit_tb passed");
    end else begin
      $display("html_script_extractor_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_queue.sv
rtl/hse_back.sv
rtl/html_script_extractor_unit.sv
tb/html_script_extractor_unit_tb.sv
